@@ rtl/mdio_ps_pkg.sv @@
// Shared types and constants for the bit-banged MDIO PHY slave.
// Used by the decoder, the PHY register file, the output buffer and the top level.
package mdio_ps_pkg;

  // Frame timing, counted in clock edges (both edges count).
  localparam int unsigned PREAMBLE_EDGES = 64;
  localparam int unsigned EdgeW          = 7;
  localparam logic [EdgeW-1:0] EDGE_SAT  = 7'd64;

  // PHY register file geometry.
  localparam int unsigned RegW   = 16;
  localparam int unsigned RegAw  = 5;
  localparam int unsigned NumRegs = 32;

  // Management opcodes.
  localparam logic [1:0] OP_READ = 2'b10;

  // Register numbers with special behavior.
  localparam logic [RegAw-1:0] REG_CONTROL   = 5'd0;
  localparam logic [RegAw-1:0] REG_STATUS    = 5'd1;
  localparam logic [RegAw-1:0] REG_ID1       = 5'd2;
  localparam logic [RegAw-1:0] REG_ID2       = 5'd3;
  localparam logic [RegAw-1:0] REG_ADVERTISE = 5'd4;
  localparam logic [RegAw-1:0] REG_PARTNER   = 5'd5;
  localparam logic [RegAw-1:0] REG_DIAG      = 5'd18;

  // Fixed words.
  localparam logic [RegW-1:0] STATUS_LINK_WORD  = 16'h782C;
  localparam logic [RegW-1:0] PARTNER_BASE_WORD = 16'h4001;
  localparam logic [RegW-1:0] PARTNER_ADV_MASK  = 16'h01E0;
  localparam logic [RegW-1:0] ADV_FAST_MASK     = 16'h0180;
  localparam logic [RegW-1:0] ADV_FULL_MASK     = 16'h0140;
  localparam logic [RegW-1:0] NO_DEVICE_WORD    = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PHY_ADDRESS = 1'b0,
    CFG_LINK_UP     = 1'b1
  } cfg_index_e;

  // Write request from the frame decoder into the PHY register file.
  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [RegW-1:0]  data;
  } reg_wr_t;

  // Reset contents of the PHY register file.
  function automatic logic [RegW-1:0] reg_reset_value(input logic [RegAw-1:0] idx);
    logic [RegW-1:0] v;
    v = '0;
    case (idx)
      REG_CONTROL:   v = 16'h3100;
      REG_ID1:       v = 16'h0300;
      REG_ID2:       v = 16'hE400;
      REG_ADVERTISE: v = 16'h01E1;
      default:       v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/mdio_ps_regfile.sv @@
// Embedded PHY register model: 32 stored words plus the computed status,
// partner-ability and diagnostic words. Depends on mdio_ps_pkg.
module mdio_ps_regfile import mdio_ps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             link_up_i,
  input  reg_wr_t          wr_i,
  input  logic [RegAw-1:0] rd_addr_i,
  output logic [RegW-1:0]  rd_data_o
);

  logic [RegW-1:0] regs_q [NumRegs];
  logic [RegW-1:0] adv;
  logic            fast;
  logic            full;

  // Storage with the PHY's power-on contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= reg_reset_value(RegAw'(i));
      end
    end else if (wr_i.en) begin
      regs_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read side: a few registers are derived from the advertisement word and link.
  assign adv  = regs_q[REG_ADVERTISE];
  assign fast = |(adv & ADV_FAST_MASK);
  assign full = |(adv & ADV_FULL_MASK);

  always_comb begin
    unique case (rd_addr_i)
      REG_STATUS:  rd_data_o = link_up_i ? STATUS_LINK_WORD : '0;
      REG_PARTNER: rd_data_o = PARTNER_BASE_WORD | (adv & PARTNER_ADV_MASK);
      REG_DIAG:    rd_data_o = link_up_i ? {4'b0, full, fast, 10'b0} : '0;
      default:     rd_data_o = regs_q[rd_addr_i];
    endcase
  end

endmodule

@@ rtl/mdio_ps_decoder.sv @@
// Clause 22 frame decoder: tracks the software-driven clock and data line and
// steps through the frame one edge at a time. Depends on mdio_ps_pkg.
module mdio_ps_decoder import mdio_ps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             mdc_level_i,
  input  logic             drive_enable_i,
  input  logic             data_value_i,
  input  logic [RegAw-1:0] phy_address_i,
  input  logic [RegW-1:0]  rd_data_i,
  output logic [RegAw-1:0] rd_addr_o,
  output reg_wr_t          wr_o,
  output logic             line_o
);

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_START,
    PH_OPCODE,
    PH_ADDRESS,
    PH_REGISTER,
    PH_TURN,
    PH_DATA
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             clock_q, clock_d;
  logic             line_q, line_d;
  logic [EdgeW-1:0] count_q, count_d;
  logic [1:0]       op_q, op_d;
  logic [RegAw-1:0] addr_q, addr_d;
  logic [RegAw-1:0] regnum_q, regnum_d;
  logic [RegW-1:0]  shift_q, shift_d;
  logic             driving_q, driving_d;
  logic             was_high;
  logic             line_in;
  logic [EdgeW-1:0] count_inc;
  logic             addr_match;

  assign rd_addr_o  = regnum_q;
  assign addr_match = (addr_q == phy_address_i);
  assign was_high   = clock_q;
  assign line_in    = drive_enable_i ? data_value_i : line_q;
  assign count_inc  = (count_q < EDGE_SAT) ? count_q + 1'b1 : count_q;

  // Next-state logic for one beat: software drive first, then one decoder step
  // if the clock level changed.
  always_comb begin
    phase_d   = phase_q;
    clock_d   = clock_q;
    line_d    = line_q;
    count_d   = count_q;
    op_d      = op_q;
    addr_d    = addr_q;
    regnum_d  = regnum_q;
    shift_d   = shift_q;
    driving_d = driving_q;
    wr_o      = '{en: 1'b0, addr: regnum_q, data: shift_q};

    if (step_i) begin
      line_d  = line_in;
      clock_d = mdc_level_i;
      if (mdc_level_i != clock_q) begin
        count_d = count_inc;
        unique case (phase_q)
          PH_PREAMBLE: begin
            if (was_high && count_inc >= EdgeW'(PREAMBLE_EDGES) && !line_in) begin
              count_d = '0;
              shift_d = '0;
              phase_d = PH_START;
            end
          end
          PH_START: begin
            if (was_high && count_inc == 7'd2) begin
              count_d = '0;
              op_d    = '0;
              phase_d = PH_OPCODE;
            end
          end
          PH_OPCODE: begin
            if (was_high) begin
              op_d = {op_q[0], line_in};
              if (count_inc == 7'd4) begin
                count_d = '0;
                addr_d  = '0;
                phase_d = PH_ADDRESS;
              end
            end
          end
          PH_ADDRESS: begin
            if (was_high) begin
              addr_d = {addr_q[RegAw-2:0], line_in};
              if (count_inc == 7'd10) begin
                count_d  = '0;
                regnum_d = '0;
                phase_d  = PH_REGISTER;
              end
            end
          end
          PH_REGISTER: begin
            if (was_high) begin
              regnum_d = {regnum_q[RegAw-2:0], line_in};
              if (count_inc == 7'd10) begin
                count_d = '0;
                phase_d = PH_TURN;
              end
            end
          end
          PH_TURN: begin
            if (was_high && count_inc == 7'd4) begin
              line_d  = 1'b0;
              count_d = '0;
              if (op_q == OP_READ) begin
                driving_d = 1'b1;
                shift_d   = addr_match ? rd_data_i : NO_DEVICE_WORD;
                line_d    = shift_d[0];
              end
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            if (!was_high) begin
              // Rising edge: the slave presents its next bit.
              if (driving_q) begin
                line_d  = shift_q[RegW-1];
                shift_d = {shift_q[RegW-2:0], 1'b0};
              end
            end else begin
              // Falling edge: sample a write bit and close the frame at the end.
              if (!driving_q) begin
                shift_d = {shift_q[RegW-2:0], line_in};
              end
              if (count_inc == 7'd32) begin
                count_d   = '0;
                phase_d   = PH_PREAMBLE;
                wr_o.en   = !driving_q && addr_match;
                wr_o.data = shift_d;
                driving_d = 1'b0;
              end
            end
          end
          default: phase_d = PH_PREAMBLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREAMBLE;
      clock_q   <= 1'b0;
      line_q    <= 1'b0;
      count_q   <= '0;
      op_q      <= '0;
      addr_q    <= '0;
      regnum_q  <= '0;
      shift_q   <= '0;
      driving_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      clock_q   <= clock_d;
      line_q    <= line_d;
      count_q   <= count_d;
      op_q      <= op_d;
      addr_q    <= addr_d;
      regnum_q  <= regnum_d;
      shift_q   <= shift_d;
      driving_q <= driving_d;
    end
  end

  assign line_o = line_d;

endmodule

@@ rtl/mdio_ps_outbuf.sv @@
// Two-entry result buffer (output register plus skid register) that keeps the
// input side free while a result waits. Depends on mdio_ps_pkg.
module mdio_ps_outbuf import mdio_ps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output logic data_o
);

  logic out_valid_q, skid_valid_q;
  logic out_q, skid_q;
  logic pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Control: the skid stage only fills when the output is held and a beat arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !pop && push_i) begin
      skid_valid_q <= 1'b1;
    end else if (push_i) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !pop && push_i) begin
      skid_q <= data_i;
    end else if (push_i) begin
      out_q <= data_i;
    end
  end

endmodule

@@ rtl/mdio_bitbang_phy_slave.sv @@
// Top level of the bit-banged MDIO PHY slave: configuration registers, frame
// decoder, PHY register file and result buffer. Depends on mdio_ps_pkg.
//
// Each input beat is one software write of the MDC level, a drive-enable bit
// and a data value; the block answers every beat with one result beat, the
// MDIO line level after that write. A beat is handled combinationally by the
// frame decoder and the register-file read logic, so one beat is accepted per
// clock and its result is registered in a two-entry output buffer that keeps
// input accepted while a result waits; input stalls only once two results are
// pending. Configuration (index 0: PHY address, index 1: link up) has its own
// port, always ready; the user must write it only while the block is idle, and the block does not enforce this.
module mdio_bitbang_phy_slave import mdio_ps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mdc_level_i,
  input  logic             drive_enable_i,
  input  logic             data_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             mdio_line_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [RegAw-1:0] cfg_data_i
);

  logic [RegAw-1:0] phy_address_q;
  logic             link_up_q;
  logic             accept;
  logic [RegAw-1:0] rd_addr;
  logic [RegW-1:0]  rd_data;
  reg_wr_t          wr;
  logic             line;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phy_address_q <= '0;
      link_up_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PHY_ADDRESS: phy_address_q <= cfg_data_i;
        CFG_LINK_UP:     link_up_q     <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  mdio_ps_decoder u_decoder (
    .clk_i,
    .rst_ni,
    .step_i         (accept),
    .mdc_level_i,
    .drive_enable_i,
    .data_value_i,
    .phy_address_i  (phy_address_q),
    .rd_data_i      (rd_data),
    .rd_addr_o      (rd_addr),
    .wr_o           (wr),
    .line_o         (line)
  );

  mdio_ps_regfile u_regfile (
    .clk_i,
    .rst_ni,
    .link_up_i (link_up_q),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mdio_ps_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  (line),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (mdio_line_o)
  );

endmodule

@@ tb/tb_mdio_bitbang_phy_slave.sv @@
// Self-checking testbench for the bit-banged MDIO PHY slave: directed beats and
// frames, then random frames and noise, checked beat by beat against a local line-level
// model or typed-in levels. Depends on mdio_ps_pkg and mdio_bitbang_phy_slave.
`timescale 1ns / 1ps

module tb_mdio_bitbang_phy_slave;
  import mdio_ps_pkg::*;

  // Frame field lengths in clock edges, both edges counted.
  localparam int unsigned START_EDGES  = 2;
  localparam int unsigned OPCODE_EDGES = 4;
  localparam int unsigned FIELD_EDGES  = 10;
  localparam int unsigned TURN_EDGES   = 4;
  localparam int unsigned DATA_EDGES   = 32;

  // Opcodes other than read; all of them act as writes.
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_ALT0  = 2'b00;
  localparam logic [1:0] OP_ALT3  = 2'b11;

  localparam logic [RegAw-1:0] ADDR_ZERO = 5'd0;
  localparam logic [RegAw-1:0] ADDR_TOP  = 5'd31;
  localparam logic [RegAw-1:0] REG_LAST  = 5'd31;

  localparam int DIAG_FAST_BIT = 10;
  localparam int DIAG_FULL_BIT = 11;

  localparam int RANDOM_BEATS  = 500;
  localparam int RANDOM_PHASES = 4;
  localparam int FULL_FRAME    = 1000;
  localparam int CFG_SETTLE    = 4;
  localparam int END_SETTLE    = 10;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_FIRST    = 300;
  localparam int HOLD_SPACING  = 900;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 50;

  typedef enum logic [2:0] {
    FR_PREAMBLE, FR_START, FR_OPCODE, FR_ADDR, FR_REGNUM, FR_TURN, FR_DATA
  } frame_phase_e;

  typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             mdc;
    logic             drv;
    logic             val;
    logic             has_exp;
    logic             exp;
    logic [1:0]       op;
    logic [RegAw-1:0] addr;
    logic [RegAw-1:0] regnum;
    logic [RegW-1:0]  data;
    logic             sw_drive;
    cfg_index_e       cfg_idx;
    logic [RegAw-1:0] cfg_val;
  } stim_row_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             mdc_level_i    = 1'b0;
  logic             drive_enable_i = 1'b0;
  logic             data_value_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic             mdio_line_o;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  cfg_index_e       cfg_index_i    = CFG_PHY_ADDRESS;
  logic [RegAw-1:0] cfg_data_i     = '0;

  // Typed-in expectation that travels with the beat on the input port.
  logic cur_has_exp = 1'b0;
  logic cur_exp     = 1'b0;

  // Line-level model state and its copy of the configuration.
  logic             m_clk;
  logic             m_line;
  frame_phase_e     m_phase;
  logic [EdgeW-1:0] m_edges;
  logic [1:0]       m_op;
  logic [RegAw-1:0] m_addr;
  logic [RegAw-1:0] m_regnum;
  logic [RegW-1:0]  m_shift;
  logic             m_driving;
  logic [RegW-1:0]  m_regs [NumRegs];
  logic [RegAw-1:0] cfg_phy_addr;
  logic             cfg_link;

  logic pending_line_levels [$];
  int   mismatches  = 0;
  int   beats_in    = 0;
  int   beats_sent  = 0;
  int   idle_cycles = 0;
  bit   calm        = 1'b0;
  int   hold_left   = 0;
  int   stall_left  = 0;
  int   holds_done  = 0;

  mdio_bitbang_phy_slave i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mdc_level_i    (mdc_level_i),
    .drive_enable_i (drive_enable_i),
    .data_value_i   (data_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mdio_line_o    (mdio_line_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Word the embedded PHY returns for a read of the given register.
  function automatic logic [RegW-1:0] phy_word(input logic [RegAw-1:0] regnum);
    logic [RegW-1:0] adv;
    logic [RegW-1:0] w;
    adv = m_regs[REG_ADVERTISE];
    w   = m_regs[regnum];
    case (regnum)
      REG_STATUS:  w = cfg_link ? STATUS_LINK_WORD : '0;
      REG_PARTNER: w = PARTNER_BASE_WORD | (adv & PARTNER_ADV_MASK);
      REG_DIAG: begin
        w = '0;
        if (cfg_link) begin
          w[DIAG_FAST_BIT] = |(adv & ADV_FAST_MASK);
          w[DIAG_FULL_BIT] = |(adv & ADV_FULL_MASK);
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // Frame decoder step on one MDC transition; the old clock level tells the direction.
  function automatic void mdc_transition();
    logic was_high;
    was_high = m_clk;
    if (m_edges < EDGE_SAT) m_edges++;
    case (m_phase)
      FR_PREAMBLE: begin
        if (was_high && m_edges >= PREAMBLE_EDGES && !m_line) begin
          m_edges = '0;
          m_phase = FR_START;
          m_shift = '0;
        end
      end
      FR_START: begin
        if (was_high && m_edges == START_EDGES) begin
          m_edges = '0;
          m_op    = '0;
          m_phase = FR_OPCODE;
        end
      end
      FR_OPCODE: begin
        if (was_high) begin
          m_op = {m_op[0], m_line};
          if (m_edges == OPCODE_EDGES) begin
            m_edges = '0;
            m_addr  = '0;
            m_phase = FR_ADDR;
          end
        end
      end
      FR_ADDR: begin
        if (was_high) begin
          m_addr = {m_addr[RegAw-2:0], m_line};
          if (m_edges == FIELD_EDGES) begin
            m_edges  = '0;
            m_regnum = '0;
            m_phase  = FR_REGNUM;
          end
        end
      end
      FR_REGNUM: begin
        if (was_high) begin
          m_regnum = {m_regnum[RegAw-2:0], m_line};
          if (m_edges == FIELD_EDGES) begin
            m_edges = '0;
            m_phase = FR_TURN;
          end
        end
      end
      FR_TURN: begin
        if (was_high && m_edges == TURN_EDGES) begin
          m_line  = 1'b0;
          m_edges = '0;
          if (m_op == OP_READ) begin
            m_driving = 1'b1;
            m_shift   = (m_addr == cfg_phy_addr) ? phy_word(m_regnum) : NO_DEVICE_WORD;
            m_line    = m_shift[0];
          end
          m_phase = FR_DATA;
        end
      end
      FR_DATA: begin
        if (!was_high) begin
          if (m_driving) begin
            m_line  = m_shift[RegW-1];
            m_shift = {m_shift[RegW-2:0], 1'b0};
          end
        end else begin
          if (!m_driving) m_shift = {m_shift[RegW-2:0], m_line};
          if (m_edges == DATA_EDGES) begin
            m_edges = '0;
            m_phase = FR_PREAMBLE;
            if (!m_driving && m_addr == cfg_phy_addr) m_regs[m_regnum] = m_shift;
            m_driving = 1'b0;
          end
        end
      end
      default: m_phase = FR_PREAMBLE;
    endcase
  endfunction

  // Line level after one software write of the control register.
  function automatic logic predict_line(input logic mdc, input logic drv, input logic val);
    if (drv) m_line = val;
    if (mdc != m_clk) mdc_transition();
    m_clk = mdc;
    return m_line;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Short gaps mostly, a few long ones, none during calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Accepted beats: predict on input, check on output, track configuration writes.
  always @(posedge clk_i) begin : scoreboard
    logic predicted;
    logic want;
    bit   busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        busy = 1'b1;
        case (cfg_index_i)
          CFG_PHY_ADDRESS: cfg_phy_addr = cfg_data_i;
          CFG_LINK_UP:     cfg_link     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        predicted = predict_line(mdc_level_i, drive_enable_i, data_value_i);
        pending_line_levels.push_back(cur_has_exp ? cur_exp : predicted);
        beats_in++;
      end
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        if (pending_line_levels.size() == 0) begin
          report_mismatch("result beat with no line level expected");
        end else begin
          want = pending_line_levels.pop_front();
          if (mdio_line_o !== want)
            report_mismatch($sformatf("mdio_line %b, expected %b", mdio_line_o, want));
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus long hold-offs that fill the block up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_done < 2 && beats_in >= HOLD_FIRST + holds_done * HOLD_SPACING) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready_i <= (stall_left == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Alternate between stretches with random idling and stretches without.
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm = ~calm;
    end
  end

  // Ends the run when nothing has been accepted for too long.
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Send one control-register write; called and returns at a falling edge.
  task automatic send_beat(input logic mdc, input logic drv, input logic val,
                           input logic has_exp, input logic exp);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mdc_level_i    <= mdc;
    drive_enable_i <= drv;
    data_value_i   <= val;
    cur_has_exp    <= has_exp;
    cur_exp        <= exp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Bit-bang a clause 22 frame, MSB first; stop after bit_limit bits for broken frames.
  task automatic send_frame(input logic [1:0] op, input logic [RegAw-1:0] addr,
                            input logic [RegAw-1:0] regnum, input logic [RegW-1:0] data,
                            input logic sw_drive, input int pre_bits, input int bit_limit);
    logic [1:0] bits_q [$];
    logic       is_read;
    int         n;
    is_read = (op == OP_READ);
    repeat (pre_bits) bits_q.push_back(2'b11);
    bits_q.push_back(2'b10);
    bits_q.push_back(2'b11);
    for (int i = 1; i >= 0; i--) bits_q.push_back({1'b1, op[i]});
    for (int i = RegAw - 1; i >= 0; i--) bits_q.push_back({1'b1, addr[i]});
    for (int i = RegAw - 1; i >= 0; i--) bits_q.push_back({1'b1, regnum[i]});
    // Turnaround and data: released by software on a read unless it keeps driving.
    for (int i = 0; i < 2; i++) begin
      if (is_read) bits_q.push_back({sw_drive, 1'($urandom)});
      else bits_q.push_back({1'b1, (i == 0)});
    end
    for (int i = RegW - 1; i >= 0; i--) begin
      if (is_read) bits_q.push_back({sw_drive, 1'($urandom)});
      else bits_q.push_back({1'b1, data[i]});
    end
    n = 0;
    while (n < bits_q.size() && n < bit_limit) begin
      send_beat(1'b1, bits_q[n][1], bits_q[n][0], 1'b0, 1'b0);
      send_beat(1'b0, bits_q[n][1], bits_q[n][0], 1'b0, 1'b0);
      n++;
    end
  endtask

  task automatic wait_drained();
    while (pending_line_levels.size() != 0) @(negedge clk_i);
  endtask

  // Configuration writes happen only with nothing in flight.
  task automatic write_cfg(input cfg_index_e idx, input logic [RegAw-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic stim_row_t beat_row(input logic mdc, input logic drv, input logic val,
                                         input logic exp);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_BEAT;
    r.mdc     = mdc;
    r.drv     = drv;
    r.val     = val;
    r.has_exp = 1'b1;
    r.exp     = exp;
    return r;
  endfunction

  function automatic stim_row_t frame_row(input logic [1:0] op, input logic [RegAw-1:0] addr,
                                          input logic [RegAw-1:0] regnum,
                                          input logic [RegW-1:0] data, input logic sw_drive);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_FRAME;
    r.op       = op;
    r.addr     = addr;
    r.regnum   = regnum;
    r.data     = data;
    r.sw_drive = sw_drive;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_index_e idx, input logic [RegAw-1:0] value);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = value;
    return r;
  endfunction

  initial begin
    stim_row_t        rows [$];
    int               phase_start;
    int               pick;
    logic [1:0]       op;
    logic [RegAw-1:0] addr;
    logic [RegAw-1:0] regnum;
    logic [RegAw-1:0] addr_pick;
    logic             link_pick;

    // Model state after reset.
    m_clk        = 1'b0;
    m_line       = 1'b0;
    m_phase      = FR_PREAMBLE;
    m_edges      = '0;
    m_op         = '0;
    m_addr       = '0;
    m_regnum     = '0;
    m_shift      = '0;
    m_driving    = 1'b0;
    cfg_phy_addr = ADDR_ZERO;
    cfg_link     = 1'b1;
    foreach (m_regs[i]) m_regs[i] = '0;
    m_regs[REG_CONTROL]   = 16'h3100;
    m_regs[REG_ID1]       = 16'h0300;
    m_regs[REG_ID2]       = 16'hE400;
    m_regs[REG_ADVERTISE] = 16'h01E1;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: line drive without and with clock changes, then one frame
    // per special case (computed words, other opcodes, address mismatch,
    // software driving during a read, link down).
    rows.push_back(cfg_row(CFG_PHY_ADDRESS, ADDR_ZERO));
    rows.push_back(cfg_row(CFG_LINK_UP, 5'd1));
    rows.push_back(beat_row(1'b0, 1'b1, 1'b1, 1'b1));
    rows.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b1));
    rows.push_back(beat_row(1'b0, 1'b1, 1'b0, 1'b0));
    rows.push_back(beat_row(1'b1, 1'b0, 1'b1, 1'b0));
    rows.push_back(beat_row(1'b1, 1'b1, 1'b1, 1'b1));
    rows.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b1));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_STATUS,    16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_PARTNER,   16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_DIAG,      16'h0000, 1'b0));
    rows.push_back(frame_row(OP_WRITE, ADDR_ZERO, REG_ADVERTISE, 16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_PARTNER,   16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_DIAG,      16'h0000, 1'b0));
    rows.push_back(frame_row(OP_ALT0,  ADDR_ZERO, REG_ADVERTISE, 16'hFFFF, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_DIAG,      16'h0000, 1'b0));
    rows.push_back(frame_row(OP_ALT3,  ADDR_ZERO, REG_LAST,      16'hA5C3, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_LAST,      16'h0000, 1'b0));
    rows.push_back(frame_row(OP_WRITE, ADDR_ZERO, REG_STATUS,    16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_STATUS,    16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_TOP,  REG_CONTROL,   16'h0000, 1'b0));
    rows.push_back(frame_row(OP_WRITE, ADDR_TOP,  REG_CONTROL,   16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_CONTROL,   16'h0000, 1'b1));
    rows.push_back(cfg_row(CFG_LINK_UP, 5'd0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_STATUS,    16'h0000, 1'b0));
    rows.push_back(frame_row(OP_READ,  ADDR_ZERO, REG_DIAG,      16'h0000, 1'b0));

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG:  write_cfg(rows[i].cfg_idx, rows[i].cfg_val);
        ROW_BEAT: send_beat(rows[i].mdc, rows[i].drv, rows[i].val,
                            rows[i].has_exp, rows[i].exp);
        default:  send_frame(rows[i].op, rows[i].addr, rows[i].regnum, rows[i].data,
                             rows[i].sw_drive, PREAMBLE_EDGES / 2, FULL_FRAME);
      endcase
    end

    // Random part: a few configuration settings, the extremes first, each with
    // mostly well-formed frames and some broken frames and noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          addr_pick = ADDR_TOP;
          link_pick = 1'b1;
        end
        1: begin
          addr_pick = ADDR_ZERO;
          link_pick = 1'b0;
        end
        default: begin
          addr_pick = RegAw'($urandom);
          link_pick = 1'($urandom);
        end
      endcase
      write_cfg(CFG_PHY_ADDRESS, addr_pick);
      write_cfg(CFG_LINK_UP, {4'($urandom), link_pick});
      phase_start = beats_sent;
      while (beats_sent - phase_start < RANDOM_BEATS / RANDOM_PHASES) begin
        op   = ($urandom_range(0, 1) != 0) ? OP_READ : 2'($urandom);
        addr = ($urandom_range(0, 2) != 0) ? cfg_phy_addr : RegAw'($urandom);
        case ($urandom_range(0, 9))
          0:       regnum = REG_STATUS;
          1:       regnum = REG_ADVERTISE;
          2:       regnum = REG_PARTNER;
          3:       regnum = REG_DIAG;
          default: regnum = RegAw'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame(op, addr, regnum, RegW'($urandom), ($urandom_range(0, 9) == 0),
                     PREAMBLE_EDGES / 2 + $urandom_range(0, 3), FULL_FRAME);
        end else if (pick < 85) begin
          send_frame(op, addr, regnum, RegW'($urandom), 1'($urandom),
                     PREAMBLE_EDGES / 2, $urandom_range(1, 60));
        end else begin
          repeat ($urandom_range(1, 12))
            send_beat(1'($urandom), 1'($urandom), 1'($urandom), 1'b0, 1'b0);
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ mdio_bitbang_phy_slave.f @@
rtl/mdio_ps_pkg.sv
rtl/mdio_ps_regfile.sv
rtl/mdio_ps_decoder.sv
rtl/mdio_ps_outbuf.sv
rtl/mdio_bitbang_phy_slave.sv
tb/tb_mdio_bitbang_phy_slave.sv
